// ===== rtl/packed_list_entry_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Packed-list decoder assertion macros
// Concurrent assertion shorthands shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef PACKED_LIST_ENTRY_DECODER_MACROS_SVH
`define PACKED_LIST_ENTRY_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PLDE_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("plde assertion failed");

// next-cycle implication, disabled in reset
`define PLDE_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("plde assertion failed");

`endif

// ===== rtl/plde_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed-list decoder package
// Request/result types, event codes and parser phases.
// ----------------------------------------------------------------------------
package plde_pkg;

  localparam logic [7:0] END_MARK_DEF = 8'hFF;
  localparam logic [7:0] BLEN_LONG    = 8'd254;
  localparam logic [7:0] ENC_STR32    = 8'hE0;
  localparam logic [7:0] ENC_INT64    = 8'hF0;

  localparam logic [2:0] HDR_LAST  = 3'd5;
  localparam logic [2:0] LE32_LAST = 3'd3;
  localparam logic [2:0] LE64_LAST = 3'd7;

  localparam logic [2:0] EV_HEADER    = 3'd0;
  localparam logic [2:0] EV_INTEGER   = 3'd1;
  localparam logic [2:0] EV_STR_START = 3'd2;
  localparam logic [2:0] EV_STR_BYTE  = 3'd3;
  localparam logic [2:0] EV_END       = 3'd4;
  localparam logic [2:0] EV_BAD_ENC   = 3'd5;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HDR    = 8'b0000_0010,
    PH_ESTART = 8'b0000_0100,
    PH_BLEN   = 8'b0000_1000,
    PH_ENC    = 8'b0001_0000,
    PH_SLEN   = 8'b0010_0000,
    PH_INT    = 8'b0100_0000,
    PH_STR    = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_in;
    logic       start_req;
  } plde_req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic signed [63:0] int_value;
    logic [31:0]        str_len;
    logic [7:0]         data_out;
    logic               last_byte;
    logic [31:0]        prev_size;
    logic [15:0]        entry_number;
    logic [31:0]        list_bytes;
    logic [15:0]        list_count;
  } plde_res_t;

  typedef struct packed {
    logic step;
    logic res_valid;
  } plde_ctl_t;

endpackage

// ===== rtl/plde_parser.sv =====
// ----------------------------------------------------------------------------
// Packed-list parser core
// Holds the parse state and decodes one buffer byte per step into at most
// one result.
// ----------------------------------------------------------------------------
module plde_parser #(
  parameter logic [7:0] END_MARK = plde_pkg::END_MARK_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  plde_pkg::plde_req_t req_i,
  output plde_pkg::plde_ctl_t ctl_o,
  output plde_pkg::plde_res_t res_o
);
  import plde_pkg::*;

  phase_e          phase_q, phase_d, ph;
  logic [2:0]      cnt_q, cnt_d, cnt;
  logic [15:0]     ent_q, ent_d, ent;
  logic [7:0][7:0] asm_q, asm_d, asm_w;
  logic [31:0]     blen_q, blen_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     hdr_bytes_q, hdr_bytes_d;
  logic [15:0]     hdr_count_q, hdr_count_d;
  logic            str_go;
  logic [31:0]     str_len;
  logic            done;
  logic            res_valid;
  plde_res_t       res;
  logic [7:0]      b;

  always_comb begin
    b           = req_i.data_in;
    ph          = req_i.start_req ? PH_HDR : phase_q;
    cnt         = req_i.start_req ? 3'd0 : cnt_q;
    ent         = req_i.start_req ? 16'd0 : ent_q;
    asm_w       = asm_q;
    asm_w[cnt]  = b;
    phase_d     = ph;
    cnt_d       = cnt;
    ent_d       = ent;
    asm_d       = asm_q;
    blen_d      = blen_q;
    rem_d       = rem_q;
    hdr_bytes_d = hdr_bytes_q;
    hdr_count_d = hdr_count_q;
    str_go      = 1'b0;
    str_len     = '0;
    done        = 1'b0;
    res_valid   = 1'b0;
    res              = '0;
    res.prev_size    = blen_q;
    res.entry_number = ent;
    res.list_bytes   = hdr_bytes_q;
    res.list_count   = hdr_count_q;

    case (ph)
      PH_HDR: begin
        asm_d = asm_w;
        cnt_d = cnt + 3'd1;
        if (cnt == HDR_LAST) begin
          hdr_bytes_d      = asm_w[3:0];
          hdr_count_d      = asm_w[5:4];
          res.event_res    = EV_HEADER;
          res.prev_size    = '0;
          res.entry_number = '0;
          res.list_bytes   = asm_w[3:0];
          res.list_count   = asm_w[5:4];
          res_valid        = 1'b1;
          phase_d          = PH_ESTART;
        end
      end
      PH_ESTART: begin
        if (b == END_MARK) begin
          res.event_res = EV_END;
          res.prev_size = '0;
          res_valid     = 1'b1;
          phase_d       = PH_IDLE;
        end else if (b == BLEN_LONG) begin
          cnt_d   = '0;
          phase_d = PH_BLEN;
        end else begin
          blen_d  = {24'd0, b};
          phase_d = PH_ENC;
        end
      end
      PH_BLEN: begin
        asm_d = asm_w;
        cnt_d = cnt + 3'd1;
        if (cnt == LE32_LAST) begin
          blen_d  = asm_w[3:0];
          phase_d = PH_ENC;
        end
      end
      PH_ENC: begin
        cnt_d = '0;
        if (!b[7]) begin
          res.event_res = EV_INTEGER;
          res.int_value = {56'd0, b};
          res_valid     = 1'b1;
          done          = 1'b1;
        end else if (!b[6]) begin
          str_go  = 1'b1;
          str_len = {26'd0, b[5:0]};
        end else if (b == ENC_STR32) begin
          phase_d = PH_SLEN;
        end else if (b == ENC_INT64) begin
          phase_d = PH_INT;
        end else begin
          res.event_res = EV_BAD_ENC;
          res_valid     = 1'b1;
          phase_d       = PH_IDLE;
        end
      end
      PH_SLEN: begin
        asm_d = asm_w;
        cnt_d = cnt + 3'd1;
        if (cnt == LE32_LAST) begin
          str_go  = 1'b1;
          str_len = asm_w[3:0];
        end
      end
      PH_INT: begin
        asm_d = asm_w;
        cnt_d = cnt + 3'd1;
        if (cnt == LE64_LAST) begin
          res.event_res = EV_INTEGER;
          res.int_value = asm_w;
          res_valid     = 1'b1;
          done          = 1'b1;
        end
      end
      PH_STR: begin
        rem_d         = rem_q - 32'd1;
        res.event_res = EV_STR_BYTE;
        res.data_out  = b;
        res.last_byte = (rem_q == 32'd1);
        res_valid     = 1'b1;
        done          = (rem_q == 32'd1);
      end
      default: begin
      end
    endcase

    if (str_go) begin
      res.event_res = EV_STR_START;
      res.str_len   = str_len;
      res_valid     = 1'b1;
      rem_d         = str_len;
      if (str_len == '0) begin
        done = 1'b1;
      end else begin
        phase_d = PH_STR;
      end
    end

    if (done) begin
      ent_d   = ent + 16'd1;
      phase_d = PH_ESTART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      ent_q       <= '0;
      hdr_bytes_q <= '0;
      hdr_count_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      ent_q       <= ent_d;
      hdr_bytes_q <= hdr_bytes_d;
      hdr_count_q <= hdr_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      asm_q  <= asm_d;
      blen_q <= blen_d;
      rem_q  <= rem_d;
    end
  end

  assign ctl_o.step      = step_i;
  assign ctl_o.res_valid = res_valid;
  assign res_o           = res;

`include "packed_list_entry_decoder_macros.svh"

  `PLDE_ASSERT_IMP(a_phase_onehot, clk_i, rst_ni, 1'b1, $onehot(phase_q))
  `PLDE_ASSERT_NXT(a_str_last_ends, clk_i, rst_ni,
                   step_i && !req_i.start_req && phase_q == PH_STR && rem_q == 32'd1,
                   phase_q == PH_ESTART)
  `PLDE_ASSERT_NXT(a_start_hdr, clk_i, rst_ni, step_i && req_i.start_req,
                   phase_q == PH_HDR && cnt_q == 3'd1 && ent_q == 16'd0)

endmodule

// ===== rtl/packed_list_entry_decoder.sv =====
// ----------------------------------------------------------------------------
// Packed-list entry decoder
// Byte-serial parser for packed-list buffers: header, integer and string
// entries, end marker and bad encodings, one event per completed item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------
//  request  | in        | in_valid_i / in_stall_o  | in_req_i  (plde_req_t)
//  result   | out       | out_valid_o / out_stall_i| out_res_o (plde_res_t)
//
//  One request per cycle sustained while results are not stalled; a result
//  passes the request register, then the result register, before it is valid.
//  The byte decode lies between the two registers.
//  Reset clears the parser to waiting for a header; bytes before a start
//  request yield nothing.
//  A stalled result holds the result register; the request register then
//  fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module packed_list_entry_decoder #(
  parameter logic [7:0] END_MARK = plde_pkg::END_MARK_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plde_pkg::plde_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plde_pkg::plde_res_t out_res_o
);
  import plde_pkg::*;

  logic      in_full_q, in_full_d;
  plde_req_t in_req_q;
  logic      out_full_q, out_full_d;
  plde_res_t out_res_q;
  logic      out_free;
  logic      advance;
  logic      in_take;
  plde_ctl_t ctl;
  plde_res_t res;

  assign out_free   = !out_full_q || !out_stall_i;
  assign advance    = in_full_q && out_free;
  assign in_stall_o = in_full_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  plde_parser #(
    .END_MARK(END_MARK)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .req_i (in_req_q),
    .ctl_o (ctl),
    .res_o (res)
  );

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (advance) begin
      in_full_d = 1'b0;
    end
    out_full_d = out_full_q;
    if (out_free) begin
      out_full_d = ctl.step && ctl.res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_full_d;
      out_full_q <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (advance && ctl.res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_full_q;
  assign out_res_o   = out_res_q;

`include "packed_list_entry_decoder_macros.svh"

  `PLDE_ASSERT_IMP(a_stall_needs_full, clk_i, rst_ni, in_stall_o, in_full_q && out_full_q)
  `PLDE_ASSERT_NXT(a_result_kept, clk_i, rst_ni, advance && ctl.res_valid, out_valid_o)
  `PLDE_ASSERT_NXT(a_no_phantom, clk_i, rst_ni,
                   !out_full_q && !(advance && ctl.res_valid), !out_valid_o)

endmodule

// ===== tb/sv/plde_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed-list decoder event checker
// Watches the request and result channels, runs its own byte-level parser on
// every accepted request and compares each accepted result, field by field,
// with the oldest predicted event.
// ----------------------------------------------------------------------------
module plde_event_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  plde_pkg::plde_req_t in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  plde_pkg::plde_res_t out_res_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);
  import plde_pkg::*;

  phase_e      ph;
  logic [31:0] nbytes;
  logic [63:0] acc;
  logic [31:0] back_len;
  logic [31:0] str_left;
  logic [15:0] entry_idx;
  logic [31:0] total_bytes;
  logic [15:0] elem_count;
  plde_res_t   expected_q[$];
  plde_res_t   ev;
  plde_res_t   want;
  bit          ev_valid;

  task automatic clear_parser();
    ph          = PH_IDLE;
    nbytes      = '0;
    acc         = '0;
    back_len    = '0;
    str_left    = '0;
    entry_idx   = '0;
    total_bytes = '0;
    elem_count  = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    acc    = acc | (64'(b) << (8 * nbytes[2:0]));
    nbytes = nbytes + 1;
  endtask

  task automatic post(input logic [2:0] code);
    ev              = '0;
    ev.event_res    = code;
    ev.prev_size    = back_len;
    ev.entry_number = entry_idx;
    ev_valid        = 1'b1;
  endtask

  task automatic finish_entry();
    entry_idx = entry_idx + 16'd1;
    ph        = PH_ESTART;
  endtask

  task automatic open_string(input logic [31:0] len);
    post(EV_STR_START);
    ev.str_len = len;
    str_left   = len;
    if (len == 0) begin
      finish_entry();
    end else begin
      ph = PH_STR;
    end
  endtask

  task automatic decode_byte(input plde_req_t r);
    logic [7:0] b;
    b        = r.data_in;
    ev_valid = 1'b0;
    if (r.start_req) begin
      clear_parser();
      ph = PH_HDR;
    end
    case (ph)
      PH_HDR: begin
        take_byte(b);
        if (nbytes > 32'(HDR_LAST)) begin
          total_bytes = acc[31:0];
          elem_count  = acc[47:32];
          post(EV_HEADER);
          ev.prev_size    = '0;
          ev.entry_number = '0;
          ph = PH_ESTART;
        end
      end
      PH_ESTART: begin
        // end marker wins over any back-length meaning
        if (b == END_MARK_DEF) begin
          post(EV_END);
          ev.prev_size = '0;
          ph = PH_IDLE;
        end else if (b == BLEN_LONG) begin
          nbytes = '0;
          acc    = '0;
          ph     = PH_BLEN;
        end else begin
          back_len = 32'(b);
          ph       = PH_ENC;
        end
      end
      PH_BLEN: begin
        take_byte(b);
        if (nbytes > 32'(LE32_LAST)) begin
          back_len = acc[31:0];
          ph       = PH_ENC;
        end
      end
      PH_ENC: begin
        nbytes = '0;
        acc    = '0;
        if (!b[7]) begin
          post(EV_INTEGER);
          ev.int_value = 64'(b);
          finish_entry();
        end else if (b[7:6] == 2'b10) begin
          open_string(32'(b[5:0]));
        end else if (b == ENC_STR32) begin
          ph = PH_SLEN;
        end else if (b == ENC_INT64) begin
          ph = PH_INT;
        end else begin
          post(EV_BAD_ENC);
          ph = PH_IDLE;
        end
      end
      PH_SLEN: begin
        take_byte(b);
        if (nbytes > 32'(LE32_LAST)) begin
          open_string(acc[31:0]);
        end
      end
      PH_INT: begin
        take_byte(b);
        if (nbytes > 32'(LE64_LAST)) begin
          post(EV_INTEGER);
          ev.int_value = acc;
          finish_entry();
        end
      end
      PH_STR: begin
        str_left = str_left - 1;
        post(EV_STR_BYTE);
        ev.data_out  = b;
        ev.last_byte = (str_left == 0);
        if (str_left == 0) begin
          finish_entry();
        end
      end
      default: begin
      end
    endcase
    if (ev_valid) begin
      ev.list_bytes = total_bytes;
      ev.list_count = elem_count;
      expected_q.push_back(ev);
    end
  endtask

  function automatic int field_diff(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d",
                   $time, out_res_i.event_res);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          errors_o += field_diff("event_res", 64'(want.event_res),
                                 64'(out_res_i.event_res));
          errors_o += field_diff("int_value", want.int_value, out_res_i.int_value);
          errors_o += field_diff("str_len", 64'(want.str_len), 64'(out_res_i.str_len));
          errors_o += field_diff("data_out", 64'(want.data_out),
                                 64'(out_res_i.data_out));
          errors_o += field_diff("last_byte", 64'(want.last_byte),
                                 64'(out_res_i.last_byte));
          errors_o += field_diff("prev_size", 64'(want.prev_size),
                                 64'(out_res_i.prev_size));
          errors_o += field_diff("entry_number", 64'(want.entry_number),
                                 64'(out_res_i.entry_number));
          errors_o += field_diff("list_bytes", 64'(want.list_bytes),
                                 64'(out_res_i.list_bytes));
          errors_o += field_diff("list_count", 64'(want.list_count),
                                 64'(out_res_i.list_count));
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_req_i);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/sv/packed_list_entry_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed-list entry decoder testbench
// Feeds byte streams of packed lists (well-formed lists with random entries,
// plus noise, bad encodings and restarts in mid-stream) under random gaps and
// result stalls; the event checker predicts and compares every result.
// ----------------------------------------------------------------------------
module packed_list_entry_decoder_tb;
  import plde_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         LIVE_TARGET = 1150;
  localparam logic [7:0] ENC_STR6    = 8'h80;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  plde_req_t in_req;
  logic      out_valid;
  logic      out_stall;
  plde_res_t out_res;
  int        errors;
  int        pending;
  int        checked;
  int        cycles;
  int        n_sent;
  int        n_live;
  int        n_lists;
  int        hold_req;
  bit        tx_quiet;

  always #6 clk = ~clk;

  packed_list_entry_decoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  plde_event_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_res_i  (out_res),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s, input bit live);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = '{data_in: b, start_req: s};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
    if (live) n_live++;
  endtask

  task automatic send_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8], 1'b0, 1'b1);
  endtask

  task automatic send_header(input logic [31:0] total, input logic [15:0] cnt);
    logic [47:0] h;
    h = {cnt, total};
    send_byte(h[7:0], 1'b1, 1'b1);
    send_le(64'(h >> 8), 5);
  endtask

  task automatic rand_payload(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic rand_blen();
    if ($urandom_range(0, 4) == 0) begin
      send_byte(BLEN_LONG, 1'b0, 1'b1);
      send_le(64'($urandom), 4);
    end else begin
      send_byte(8'($urandom_range(0, 253)), 1'b0, 1'b1);
    end
  endtask

  // bytes after an end or a bad encoding: parser ignores them
  task automatic trailing_noise();
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] bad_code();
    logic [7:0] b;
    do b = 8'($urandom_range(192, 255)); while (b == ENC_STR32 || b == ENC_INT64);
    return b;
  endfunction

  task automatic gen_entry();
    int kind;
    int len;
    rand_blen();
    kind = $urandom_range(0, 7);
    case (kind)
      0, 1, 2: send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b1);
      3, 4: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
        send_byte(ENC_STR6 | 8'(len), 1'b0, 1'b1);
        rand_payload(len);
      end
      5: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
        send_byte(ENC_STR32, 1'b0, 1'b1);
        send_le(64'(len), 4);
        rand_payload(len);
      end
      default: begin
        send_byte(ENC_INT64, 1'b0, 1'b1);
        send_le({$urandom, $urandom}, 8);
      end
    endcase
  endtask

  task automatic gen_list(input int n_entries, input int ending);
    logic [31:0] total;
    n_lists++;
    if ($urandom_range(0, 14) == 0) begin
      // header cut short, the next start restarts it
      send_byte(8'($urandom), 1'b1, 1'b1);
      send_le({$urandom, $urandom}, $urandom_range(0, 4));
      return;
    end
    case ($urandom_range(0, 7))
      0:       total = '0;
      1:       total = '1;
      default: total = $urandom;
    endcase
    send_header(total, 16'($urandom));
    repeat (n_entries) gen_entry();
    case (ending)
      0: begin
        send_byte(END_MARK_DEF, 1'b0, 1'b1);
        trailing_noise();
      end
      1: begin
        rand_blen();
        send_byte(bad_code(), 1'b0, 1'b1);
        trailing_noise();
      end
      default: begin
        // entry left unfinished; the next header drops it
        rand_blen();
        if ($urandom_range(0, 1) == 1) begin
          send_byte(ENC_STR32, 1'b0, 1'b1);
          send_le(64'($urandom), 4);
          rand_payload($urandom_range(0, 3));
        end else begin
          send_byte(ENC_INT64, 1'b0, 1'b1);
          rand_payload($urandom_range(0, 7));
        end
      end
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stalls per result, quiet stretches, one long hold-off
  initial begin
    int k;
    int n_rx;
    bit rx_quiet;
    bit held;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (n_rx % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      n_rx++;
      if (hold_req > 0 && !held) begin
        k    = hold_req;
        held = 1'b1;
      end else begin
        k = rx_quiet ? 0 : $urandom_range(0, 12);
      end
      if (k > 0) begin
        out_stall = 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    tx_quiet = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // ignored before a start, all-zero header, immediate end, ignored after end
    send_byte(8'h5A, 1'b0, 1'b0);
    send_header('0, '0);
    send_byte(END_MARK_DEF, 1'b0, 1'b1);
    send_byte(8'h33, 1'b0, 1'b0);
    // all-ones header, long back-length, one-byte string, empty string, bad code
    send_header('1, '1);
    send_byte(BLEN_LONG, 1'b0, 1'b1);
    send_le(64'hFFFF_FFFF, 4);
    send_byte(ENC_STR6 | 8'd1, 1'b0, 1'b1);
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'd253, 1'b0, 1'b1);
    send_byte(ENC_STR6, 1'b0, 1'b1);
    send_byte(8'd0, 1'b0, 1'b1);
    send_byte(bad_code(), 1'b0, 1'b1);
    drain();

    while (n_live < LIVE_TARGET) begin
      if (n_lists == 8) begin
        // long result hold-off while requests keep coming back to back
        hold_req = 90;
        tx_quiet = 1'b1;
        n_lists++;
        send_header($urandom, 16'($urandom));
        send_byte(8'd0, 1'b0, 1'b1);
        send_byte(8'd0, 1'b0, 1'b1);
        send_byte(8'd1, 1'b0, 1'b1);
        send_byte(8'd127, 1'b0, 1'b1);
        send_byte(8'd2, 1'b0, 1'b1);
        send_byte(ENC_INT64, 1'b0, 1'b1);
        send_le(64'h8000_0000_0000_0000, 8);
        send_byte(8'd3, 1'b0, 1'b1);
        send_byte(ENC_INT64, 1'b0, 1'b1);
        send_le(64'h7FFF_FFFF_FFFF_FFFF, 8);
        repeat (16) begin
          send_byte(8'($urandom_range(0, 253)), 1'b0, 1'b1);
          send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b1);
        end
        send_byte(END_MARK_DEF, 1'b0, 1'b1);
        drain();
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      gen_list($urandom_range(0, 8), (r < 7) ? 0 : (r < 8) ? 1 : 2);
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d request bytes (%0d parsed) in %0d lists; %0d results checked.",
             n_sent, n_live, n_lists, checked);
    $display("Covered headers, short and long integers and strings, long back-lengths,");
    $display("bad encodings, end markers, restarts and a full-stall hold-off.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
